>>> design/swtc_pkg.sv
// ----------------------------------------------------------------------------
// swtc_pkg
// shared constants and types for the sliding window tile cache
// ----------------------------------------------------------------------------
package swtc_pkg;

  localparam int RANGE_DEF = 3;
  localparam int COORD_W   = 24;
  localparam int CAM_W     = 32;
  localparam int SPAN_W    = 31;
  localparam int SLOT_W    = 8;
  localparam int ACT_W     = 2;

  localparam logic [ACT_W-1:0] ACT_LOAD   = 2'd0;
  localparam logic [ACT_W-1:0] ACT_CAMERA = 2'd1;
  localparam logic [ACT_W-1:0] ACT_CENTER = 2'd2;

  localparam logic [SPAN_W-1:0] SPAN_RESET = 31'd65536;

  // controller to datapath
  typedef struct packed {
    logic capture;    // latch input beat
    logic do_load;    // slot table write
    logic do_center;  // center write
    logic div_start;  // begin camera tile division
    logic div_step;   // one quotient bit per cycle
    logic div_fix;    // floor and saturate
    logic scan_cell;  // walk one new-window cell
    logic scan_slot;  // walk one slot
    logic scan_init;  // clear counters
    logic finish;     // commit pending count and center
    logic drain_rd;   // read last queue entry
    logic drain_wr;   // write slot and present result
  } swtc_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic has_pending;
    logic div_done;
    logic moved;
    logic cell_last;
    logic slot_last;
  } swtc_sts_t;

endpackage

>>> design/swtc_datapath.sv
// ----------------------------------------------------------------------------
// swtc_datapath
// slot table, rebuild queues, camera tile divider and window scanners
// ----------------------------------------------------------------------------
module swtc_datapath #(
  parameter int RANGE = swtc_pkg::RANGE_DEF
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  swtc_pkg::swtc_cmd_t                   cmd,
  output swtc_pkg::swtc_sts_t                   sts,
  input  logic [swtc_pkg::SPAN_W-1:0]           half_span,
  input  logic [swtc_pkg::SLOT_W-1:0]           in_slot_index,
  input  logic signed [swtc_pkg::COORD_W-1:0]   in_pos_x,
  input  logic signed [swtc_pkg::COORD_W-1:0]   in_pos_z,
  input  logic signed [swtc_pkg::CAM_W-1:0]     in_camera_x,
  input  logic signed [swtc_pkg::CAM_W-1:0]     in_camera_z,
  output logic [swtc_pkg::SLOT_W-1:0]           res_slot,
  output logic signed [swtc_pkg::COORD_W-1:0]   res_tile_x,
  output logic signed [swtc_pkg::COORD_W-1:0]   res_tile_z
);
  import swtc_pkg::*;

  localparam int SIDE   = 2 * RANGE + 1;
  localparam int NSLOTS = SIDE * SIDE;
  localparam int IDX_W  = $clog2(NSLOTS);
  localparam int CNT_W  = $clog2(NSLOTS + 1);
  localparam int SD_W   = $clog2(SIDE);
  localparam int FW     = COORD_W + 2;   // full-width cell coordinate
  localparam int NW     = CAM_W + 2;     // numerator width
  localparam int DW     = SPAN_W + 1;    // divisor width (2*h)
  localparam int QW     = NW;            // quotient bits of magnitude

  // memories
  logic signed [COORD_W-1:0] tab_x [NSLOTS];
  logic signed [COORD_W-1:0] tab_z [NSLOTS];
  logic signed [COORD_W-1:0] cel_x [NSLOTS];
  logic signed [COORD_W-1:0] cel_z [NSLOTS];
  logic [SLOT_W-1:0]         stl   [NSLOTS];

  // captured beat
  logic [SLOT_W-1:0]         idx_r;
  logic signed [COORD_W-1:0] px_r, pz_r;
  logic signed [CAM_W-1:0]   cx_r, cz_r;

  logic signed [COORD_W-1:0] ctr_x_r, ctr_z_r;
  logic [CNT_W-1:0]          pend_r;

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      idx_r <= in_slot_index;
      px_r  <= in_pos_x;
      pz_r  <= in_pos_z;
      cx_r  <= in_camera_x;
      cz_r  <= in_camera_z;
    end
  end

  // ------------------------------------------------------------------
  // divider: two axes share one restoring unit, x first then z
  // ------------------------------------------------------------------
  logic [DW-1:0]          h_eff;
  logic [DW-1:0]          den;
  logic signed [NW-1:0]   num_x, num_z;
  logic                   axis_r;    // 0 = tile x (camera_z), 1 = tile z
  logic                   neg_r;
  logic [NW-1:0]          mag_r;     // dividend shifting out
  logic [DW:0]            rem_r;
  logic [QW-1:0]          quo_r;
  logic [$clog2(QW+1)-1:0] bit_r;
  logic signed [COORD_W-1:0] tile_x_r, tile_z_r;
  logic [DW:0]            rem_sh;
  logic                   ge;
  logic signed [NW:0]     qs;
  logic signed [NW:0]     qf;
  logic signed [COORD_W-1:0] qsat;
  logic                   div_busy_r;

  assign h_eff = (half_span == '0) ? DW'(1) : {1'b0, half_span};
  assign den   = h_eff << 1;
  assign num_x = NW'(cz_r) + NW'(signed'({1'b0, h_eff}));
  assign num_z = NW'(cx_r) + NW'(signed'({1'b0, h_eff}));
  assign rem_sh = {rem_r[DW-1:0], mag_r[NW-1]};
  assign ge     = rem_sh >= {1'b0, den};

  // floor: negative with nonzero remainder rounds one further down
  always_comb begin
    qs = neg_r ? -(NW+1)'(quo_r) : (NW+1)'(quo_r);
    qf = (neg_r && rem_r != '0) ? qs - (NW+1)'(1) : qs;
    if (qf > (NW+1)'(8388607))
      qsat = 24'sh7FFFFF;
    else if (qf < -(NW+1)'(8388608))
      qsat = 24'sh800000;
    else
      qsat = qf[COORD_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      div_busy_r <= 1'b0;
      axis_r     <= 1'b0;
    end else if (cmd.div_start) begin
      div_busy_r <= 1'b1;
      axis_r     <= 1'b0;
      neg_r      <= num_x[NW-1];
      mag_r      <= num_x[NW-1] ? -num_x : num_x;
      rem_r      <= '0;
      quo_r      <= '0;
      bit_r      <= '0;
    end else if (cmd.div_step && div_busy_r) begin
      mag_r <= mag_r << 1;
      rem_r <= ge ? rem_sh - {1'b0, den} : rem_sh;
      quo_r <= {quo_r[QW-2:0], ge};
      bit_r <= bit_r + 1'b1;
      if (bit_r == ($clog2(QW+1))'(QW - 1))
        div_busy_r <= 1'b0;
    end else if (cmd.div_fix) begin
      if (!axis_r) begin
        tile_x_r   <= qsat;
        axis_r     <= 1'b1;
        div_busy_r <= 1'b1;
        neg_r      <= num_z[NW-1];
        mag_r      <= num_z[NW-1] ? -num_z : num_z;
        rem_r      <= '0;
        quo_r      <= '0;
        bit_r      <= '0;
      end else begin
        tile_z_r <= qsat;
        axis_r   <= 1'b0;
      end
    end
  end

  // ------------------------------------------------------------------
  // scanners
  // ------------------------------------------------------------------
  logic [SD_W-1:0]  cx_i_r, cz_i_r;
  logic [IDX_W-1:0] sl_r;
  logic [CNT_W-1:0] nn_r, ns_r;
  logic signed [FW-1:0] cell_x, cell_z, dx, dz, tx, tz;
  logic             cell_in_old, slot_in_new;
  // slot table read is registered, the check runs in the cycle after each read
  logic signed [COORD_W-1:0] rd_tx_r, rd_tz_r;
  logic [IDX_W-1:0]          chk_sl_r;
  logic                      chk_v_r;
  logic signed [FW-1:0] sdx, sdz;

  assign cell_x = FW'(tile_x_r) - FW'(RANGE) + FW'({1'b0, cx_i_r});
  assign cell_z = FW'(tile_z_r) - FW'(RANGE) + FW'({1'b0, cz_i_r});
  assign dx     = cell_x - FW'(ctr_x_r);
  assign dz     = cell_z - FW'(ctr_z_r);
  assign cell_in_old = (dx <= FW'(RANGE)) && (dx >= -FW'(RANGE)) &&
                       (dz <= FW'(RANGE)) && (dz >= -FW'(RANGE));

  assign tx    = FW'(tile_x_r);
  assign tz    = FW'(tile_z_r);
  assign sdx   = tx - FW'(rd_tx_r);
  assign sdz   = tz - FW'(rd_tz_r);
  assign slot_in_new = (sdx <= FW'(RANGE)) && (sdx >= -FW'(RANGE)) &&
                       (sdz <= FW'(RANGE)) && (sdz >= -FW'(RANGE));

  assign sts.cell_last = (cx_i_r == SD_W'(SIDE - 1)) && (cz_i_r == SD_W'(SIDE - 1));
  assign sts.slot_last = (sl_r == IDX_W'(NSLOTS - 1));
  assign sts.div_done  = !div_busy_r;
  assign sts.moved     = (tile_x_r != ctr_x_r) || (tile_z_r != ctr_z_r);
  assign sts.has_pending = (pend_r != '0);

  // drain read
  logic [IDX_W-1:0]          di;
  logic [SLOT_W-1:0]         d_slot_r;
  logic signed [COORD_W-1:0] d_x_r, d_z_r;
  assign di = IDX_W'(pend_r - CNT_W'(1));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctr_x_r <= '0;
      ctr_z_r <= '0;
      pend_r  <= '0;
      chk_v_r <= 1'b0;
    end else begin
      chk_v_r <= cmd.scan_slot;
      if (cmd.do_center) begin
        ctr_x_r <= px_r;
        ctr_z_r <= pz_r;
      end
      if (cmd.finish) begin
        pend_r  <= (nn_r < ns_r) ? nn_r : ns_r;
        ctr_x_r <= tile_x_r;
        ctr_z_r <= tile_z_r;
      end
      if (cmd.drain_wr)
        pend_r <= pend_r - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.scan_init) begin
      cx_i_r <= '0;
      cz_i_r <= '0;
      sl_r   <= '0;
      nn_r   <= '0;
      ns_r   <= '0;
    end
    if (cmd.scan_cell) begin
      if (!cell_in_old) begin
        cel_x[IDX_W'(nn_r)] <= cell_x[COORD_W-1:0];
        cel_z[IDX_W'(nn_r)] <= cell_z[COORD_W-1:0];
        nn_r <= nn_r + CNT_W'(1);
      end
      if (cz_i_r == SD_W'(SIDE - 1)) begin
        cz_i_r <= '0;
        cx_i_r <= cx_i_r + SD_W'(1);
      end else begin
        cz_i_r <= cz_i_r + SD_W'(1);
      end
    end
    if (cmd.scan_slot) begin
      rd_tx_r  <= tab_x[sl_r];
      rd_tz_r  <= tab_z[sl_r];
      chk_sl_r <= sl_r;
      sl_r     <= sl_r + IDX_W'(1);
    end
    if (chk_v_r && !slot_in_new) begin
      stl[IDX_W'(ns_r)] <= SLOT_W'(chk_sl_r);
      ns_r <= ns_r + CNT_W'(1);
    end
    if (cmd.drain_rd) begin
      d_slot_r <= stl[di];
      d_x_r    <= cel_x[di];
      d_z_r    <= cel_z[di];
    end
    if (cmd.do_load && idx_r < SLOT_W'(NSLOTS)) begin
      tab_x[IDX_W'(idx_r)] <= px_r;
      tab_z[IDX_W'(idx_r)] <= pz_r;
    end else if (cmd.drain_wr && d_slot_r < SLOT_W'(NSLOTS)) begin
      tab_x[IDX_W'(d_slot_r)] <= d_x_r;
      tab_z[IDX_W'(d_slot_r)] <= d_z_r;
    end
  end

  assign res_slot   = d_slot_r;
  assign res_tile_x = d_x_r;
  assign res_tile_z = d_z_r;

endmodule

>>> design/swtc_ctrl.sv
// ----------------------------------------------------------------------------
// swtc_ctrl
// sequencer for input beats, camera tile division, window scans and drain
// ----------------------------------------------------------------------------
module swtc_ctrl (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic [swtc_pkg::ACT_W-1:0]  in_action,
  input  logic                        out_stall,
  output logic                        out_valid,
  output swtc_pkg::swtc_cmd_t         cmd,
  input  swtc_pkg::swtc_sts_t         sts
);
  import swtc_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE, S_DECODE, S_DIV, S_FIX, S_CHECK, S_CELLS, S_SLOTS, S_FLUSH,
    S_FINISH, S_DRAIN, S_EMIT, S_OUT
  } state_t;

  state_t           state_r, state_nxt;
  logic [ACT_W-1:0] act_r;
  logic             out_valid_r, out_valid_nxt;
  logic             acc;

  assign acc       = in_valid && !in_stall;
  assign in_stall  = (state_r != S_IDLE);
  assign out_valid = out_valid_r;

  always_comb begin
    state_nxt     = state_r;
    out_valid_nxt = out_valid_r;
    cmd           = '0;
    cmd.capture   = acc;
    case (state_r)
      S_IDLE: if (acc) state_nxt = S_DECODE;
      S_DECODE: begin
        case (act_r)
          ACT_LOAD: begin
            cmd.do_load = 1'b1;
            state_nxt   = S_IDLE;
          end
          ACT_CENTER: begin
            cmd.do_center = 1'b1;
            state_nxt     = S_IDLE;
          end
          ACT_CAMERA: begin
            if (sts.has_pending) begin
              cmd.drain_rd = 1'b1;
              state_nxt    = S_EMIT;
            end else begin
              cmd.div_start = 1'b1;
              state_nxt     = S_DIV;
            end
          end
          default: state_nxt = S_IDLE;
        endcase
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        if (sts.div_done) state_nxt = S_FIX;
      end
      S_FIX: begin
        cmd.div_fix = 1'b1;
        state_nxt   = S_CHECK;
      end
      S_CHECK: begin
        // second axis is running if this is the first fix
        if (!sts.div_done) begin
          state_nxt = S_DIV;
        end else begin
          cmd.scan_init = 1'b1;
          state_nxt     = sts.moved ? S_CELLS : S_IDLE;
        end
      end
      S_CELLS: begin
        cmd.scan_cell = 1'b1;
        if (sts.cell_last) state_nxt = S_SLOTS;
      end
      S_SLOTS: begin
        cmd.scan_slot = 1'b1;
        if (sts.slot_last) state_nxt = S_FLUSH;
      end
      // last slot check lands here
      S_FLUSH: state_nxt = S_FINISH;
      S_FINISH: begin
        cmd.finish = 1'b1;
        state_nxt  = S_IDLE;
      end
      S_EMIT: begin
        cmd.drain_wr  = 1'b1;
        out_valid_nxt = 1'b1;
        state_nxt     = S_OUT;
      end
      S_OUT: begin
        if (!out_stall) begin
          out_valid_nxt = 1'b0;
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
    if (acc) act_r <= in_action;
  end

endmodule

>>> design/sliding_window_tile_cache.sv
// ----------------------------------------------------------------------------
// sliding_window_tile_cache
// window of tile slots that follows the camera and hands out rebuild beats
// ----------------------------------------------------------------------------
//   channel  | handshake             | payload
//   in_      | in_valid / in_stall   | action, slot_index, pos_x/z, camera_x/z
//   out_     | out_valid / out_stall | slot, tile_x, tile_z
//   cfg_     | cfg_we                | cfg_half_span
//
// one beat at a time; load and center beats finish in the decode state
// a drain beat reads the last queue entry, then writes its slot and presents
// a registered result, which holds while out_stall is high
// a camera beat runs two 34-step serial divisions, and when the center
// moved walks SIDE^2 cells then SIDE^2 slots, one per cycle, plus a read
// stage for the last slot check
// synchronous active-low reset restores the span, clears center, queue count
// and control; tables hold until written
// ----------------------------------------------------------------------------
module sliding_window_tile_cache #(
  parameter int RANGE = swtc_pkg::RANGE_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_valid,
  output logic                                 in_stall,
  input  logic [swtc_pkg::ACT_W-1:0]           in_action,
  input  logic [swtc_pkg::SLOT_W-1:0]          in_slot_index,
  input  logic signed [swtc_pkg::COORD_W-1:0]  in_pos_x,
  input  logic signed [swtc_pkg::COORD_W-1:0]  in_pos_z,
  input  logic signed [swtc_pkg::CAM_W-1:0]    in_camera_x,
  input  logic signed [swtc_pkg::CAM_W-1:0]    in_camera_z,
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output logic [swtc_pkg::SLOT_W-1:0]          out_slot,
  output logic signed [swtc_pkg::COORD_W-1:0]  out_tile_x,
  output logic signed [swtc_pkg::COORD_W-1:0]  out_tile_z,
  input  logic                                 cfg_we,
  input  logic [swtc_pkg::SPAN_W-1:0]          cfg_half_span
);
  import swtc_pkg::*;

  swtc_cmd_t          cmd;
  swtc_sts_t          sts;
  logic [SPAN_W-1:0]  half_span_r;

  // config register; the user must write it only while idle, the block itself does not enforce this
  always_ff @(posedge clk) begin
    if (!rst_n)
      half_span_r <= SPAN_RESET;
    else if (cfg_we)
      half_span_r <= cfg_half_span;
  end

  swtc_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_action (in_action),
    .out_stall (out_stall),
    .out_valid (out_valid),
    .cmd       (cmd),
    .sts       (sts)
  );

  swtc_datapath #(.RANGE(RANGE)) u_dp (
    .clk           (clk),
    .rst_n         (rst_n),
    .cmd           (cmd),
    .sts           (sts),
    .half_span     (half_span_r),
    .in_slot_index (in_slot_index),
    .in_pos_x      (in_pos_x),
    .in_pos_z      (in_pos_z),
    .in_camera_x   (in_camera_x),
    .in_camera_z   (in_camera_z),
    .res_slot      (out_slot),
    .res_tile_x    (out_tile_x),
    .res_tile_z    (out_tile_z)
  );

endmodule

>>> tb/sv/sliding_window_tile_cache_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sliding_window_tile_cache_test
// self-checking bench for the sliding window tile cache: a behavioral window
// model predicts each rebuild beat, a monitor compares every output beat with
// the oldest prediction, and sender and receiver idle at random
// ----------------------------------------------------------------------------
module sliding_window_tile_cache_test;
  import swtc_pkg::*;

  localparam int RNG     = RANGE_DEF;
  localparam int SIDE    = 2 * RNG + 1;
  localparam int NSLOTS  = SIDE * SIDE;
  localparam int SETTLE  = 400;    // settle wait, longer than the longest camera beat
  localparam int HOLDOFF = 600;    // long receiver hold-off
  localparam int WDOG    = 5000;   // cycles with no beat before giving up

  typedef struct {
    logic [SLOT_W-1:0]         slot;
    logic signed [COORD_W-1:0] tile_x;
    logic signed [COORD_W-1:0] tile_z;
  } rebuild_t;

  logic                        clk = 1'b0;
  logic                        rst_n = 1'b0;
  logic                        in_valid = 1'b0;
  logic                        in_stall;
  logic [ACT_W-1:0]            in_action = ACT_LOAD;
  logic [SLOT_W-1:0]           in_slot_index = '0;
  logic signed [COORD_W-1:0]   in_pos_x = '0;
  logic signed [COORD_W-1:0]   in_pos_z = '0;
  logic signed [CAM_W-1:0]     in_camera_x = '0;
  logic signed [CAM_W-1:0]     in_camera_z = '0;
  logic                        out_valid;
  logic                        out_stall = 1'b0;
  logic [SLOT_W-1:0]           out_slot;
  logic signed [COORD_W-1:0]   out_tile_x;
  logic signed [COORD_W-1:0]   out_tile_z;
  logic                        cfg_we = 1'b0;
  logic [SPAN_W-1:0]           cfg_half_span = SPAN_RESET;

  sliding_window_tile_cache #(.RANGE(RNG)) DUT (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall),
    .in_action(in_action), .in_slot_index(in_slot_index),
    .in_pos_x(in_pos_x), .in_pos_z(in_pos_z),
    .in_camera_x(in_camera_x), .in_camera_z(in_camera_z),
    .out_valid(out_valid), .out_stall(out_stall),
    .out_slot(out_slot), .out_tile_x(out_tile_x), .out_tile_z(out_tile_z),
    .cfg_we(cfg_we), .cfg_half_span(cfg_half_span)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // window model state
  logic [SPAN_W-1:0]         span_reg;
  logic signed [COORD_W-1:0] ctr_x, ctr_z;
  logic signed [COORD_W-1:0] tile_x_tab [NSLOTS];
  logic signed [COORD_W-1:0] tile_z_tab [NSLOTS];
  logic signed [COORD_W-1:0] cell_x_q [NSLOTS];
  logic signed [COORD_W-1:0] cell_z_q [NSLOTS];
  logic [SLOT_W-1:0]         stale_tab [NSLOTS];
  int unsigned               pending_n;

  rebuild_t rebuild_q[$];
  int       fail_count = 0;

  // idling knobs in percent: gap chance per beat, stall chance per cycle
  int unsigned tx_gap_pct = 0;
  int unsigned rx_stall_pct = 0;
  bit          hold_request = 1'b0;

  function automatic longint eff_span();
    return (span_reg == 0) ? 64'sd1 : longint'({1'b0, span_reg});
  endfunction

  // floor((cam + h) / 2h), saturated to 24 bits
  function automatic longint cam_to_tile(logic signed [CAM_W-1:0] cam, longint h);
    longint n, d, q;
    n = longint'(cam) + h;
    d = 2 * h;
    q = n / d;
    if (n % d != 0 && n < 0) q--;
    if (q > 64'sd8388607) q = 64'sd8388607;
    if (q < -64'sd8388608) q = -64'sd8388608;
    return q;
  endfunction

  function automatic longint absdiff(longint a, longint b);
    return (a > b) ? a - b : b - a;
  endfunction

  // advance the window model by one accepted beat
  task automatic predict_window(logic [ACT_W-1:0] act, logic [SLOT_W-1:0] idx,
                                logic signed [COORD_W-1:0] px,
                                logic signed [COORD_W-1:0] pz,
                                logic signed [CAM_W-1:0] cx,
                                logic signed [CAM_W-1:0] cz);
    longint   ix, iz, x, z, h;
    int       nn, ns, k;
    rebuild_t r;
    case (act)
      ACT_LOAD: begin
        if (idx < NSLOTS) begin
          tile_x_tab[idx] = px;
          tile_z_tab[idx] = pz;
        end
      end
      ACT_CENTER: begin
        ctr_x = px;
        ctr_z = pz;
      end
      ACT_CAMERA: begin
        if (pending_n > 0) begin
          k = pending_n - 1;
          r.slot   = stale_tab[k];
          r.tile_x = cell_x_q[k];
          r.tile_z = cell_z_q[k];
          tile_x_tab[r.slot] = r.tile_x;
          tile_z_tab[r.slot] = r.tile_z;
          rebuild_q.insert(rebuild_q.size(), r);
          pending_n--;
        end else begin
          h  = eff_span();
          ix = cam_to_tile(cz, h);   // axes swap: camera z gives tile x
          iz = cam_to_tile(cx, h);
          if (ix != longint'(ctr_x) || iz != longint'(ctr_z)) begin
            nn = 0;
            ns = 0;
            for (x = ix - RNG; x <= ix + RNG; x++) begin
              for (z = iz - RNG; z <= iz + RNG; z++) begin
                if (absdiff(x, ctr_x) <= RNG && absdiff(z, ctr_z) <= RNG) continue;
                cell_x_q[nn] = x[COORD_W-1:0];
                cell_z_q[nn] = z[COORD_W-1:0];
                nn++;
              end
            end
            for (int s = 0; s < NSLOTS; s++) begin
              if (absdiff(ix, tile_x_tab[s]) <= RNG && absdiff(iz, tile_z_tab[s]) <= RNG)
                continue;
              stale_tab[ns] = s[SLOT_W-1:0];
              ns++;
            end
            pending_n = (nn < ns) ? nn : ns;
            ctr_x = ix[COORD_W-1:0];
            ctr_z = iz[COORD_W-1:0];
          end
        end
      end
      default: ;  // action 3 is ignored
    endcase
  endtask

  // offer one input beat, optionally after a random gap, and wait for it
  task automatic send_beat(logic [ACT_W-1:0] act, int idx, int px, int pz,
                           int cx, int cz);
    int gap;
    gap = ($urandom_range(0, 99) < tx_gap_pct) ? $urandom_range(1, 6) : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid      <= 1'b1;
    in_action     <= act;
    in_slot_index <= idx[SLOT_W-1:0];
    in_pos_x      <= px[COORD_W-1:0];
    in_pos_z      <= pz[COORD_W-1:0];
    in_camera_x   <= cx;
    in_camera_z   <= cz;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    predict_window(act, idx[SLOT_W-1:0], px[COORD_W-1:0], pz[COORD_W-1:0], cx, cz);
  endtask

  // camera beat aimed at a tile offset from the current center
  task automatic send_camera_near(int dx, int dz);
    longint h, cx, cz;
    h  = eff_span();
    cz = (longint'(ctr_x) + dx) * 2 * h + longint'($urandom_range(0, 32'(2 * h - 1))) - h;
    cx = (longint'(ctr_z) + dz) * 2 * h + longint'($urandom_range(0, 32'(2 * h - 1))) - h;
    send_beat(ACT_CAMERA, $urandom, $urandom, $urandom, cx[CAM_W-1:0], cz[CAM_W-1:0]);
  endtask

  // drop valid and wait until every predicted beat has come out
  task automatic wait_drained();
    in_valid <= 1'b0;
    @(posedge clk);
    while (rebuild_q.size() != 0) @(posedge clk);
  endtask

  // register write, only with the block quiet
  task automatic set_span(logic [SPAN_W-1:0] v);
    wait_drained();
    repeat (SETTLE) @(posedge clk);
    cfg_we        <= 1'b1;
    cfg_half_span <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
    span_reg = v;
    @(posedge clk);
  endtask

  // load the slot table as a window around the current center
  task automatic test_prime_slots();
    for (int s = 0; s < NSLOTS; s++)
      send_beat(ACT_LOAD, s, ctr_x + s / SIDE - RNG, ctr_z + s % SIDE - RNG,
                $urandom, $urandom);
  endtask

  task automatic test_directed();
    // ignored beats: slot index past the table, top index, action 3
    send_beat(ACT_LOAD, NSLOTS, 8388607, -8388608, 0, 0);
    send_beat(ACT_LOAD, 255, -8388608, 8388607, 32'h7fffffff, 32'h80000000);
    send_beat(2'd3, 0, 8388607, 8388607, 32'h80000000, 32'h7fffffff);
    // camera inside the current tile: no move
    send_beat(ACT_CAMERA, 0, 0, 0, 0, 0);
    // one tile step in x, then drain it
    send_camera_near(1, 0);
    while (pending_n > 0) send_camera_near(0, 0);
    // diagonal jump past the whole window, partly drained with extreme camera values
    send_camera_near(-9, 5);
    send_beat(ACT_CAMERA, 0, 0, 0, 32'h80000000, 32'h7fffffff);
    send_beat(ACT_CAMERA, 0, 0, 0, 32'h7fffffff, 32'h80000000);
    // center write while work is pending leaves the queue alone
    send_beat(ACT_CENTER, 0, 8388607, -8388608, 0, 0);
    while (pending_n > 0) send_camera_near(0, 0);
    // saturated camera tile at the top of the x range and the bottom of the z range: cells wrap
    set_span(31'd1);
    send_beat(ACT_CENTER, 0, 8388606, -8388607, 0, 0);
    send_beat(ACT_CAMERA, 0, 0, 0, 32'h80000000, 32'h7fffffff);
    while (pending_n > 0) send_camera_near(0, 0);
    // widest span: tile is -1, 0 or 1 only
    set_span(31'h7fffffff);
    send_beat(ACT_CAMERA, 0, 0, 0, 32'h80000000, 32'h80000000);
    while (pending_n > 0) send_camera_near(0, 0);
    // zero span acts as one
    set_span(31'd0);
    send_beat(ACT_CAMERA, 0, 0, 0, 32'd200, -32'd301);
  endtask

  // mostly camera walks with drains, the rest loads, center writes and noise
  task automatic test_random(int n);
    int r;
    for (int i = 0; i < n; i++) begin
      r = $urandom_range(0, 99);
      if (pending_n > 0 && r < 85) begin
        send_beat(ACT_CAMERA, $urandom, $urandom, $urandom, $urandom, $urandom);
      end else if (r < 70) begin
        send_camera_near($urandom_range(0, 8) - 4, $urandom_range(0, 8) - 4);
      end else if (r < 80) begin
        send_beat(ACT_LOAD, $urandom_range(0, 255), ctr_x + $urandom_range(0, 8) - 4,
                  ctr_z + $urandom_range(0, 8) - 4, $urandom, $urandom);
      end else if (r < 84) begin
        send_beat(ACT_LOAD, $urandom, $urandom, $urandom, $urandom, $urandom);
      end else if (r < 90) begin
        send_beat(ACT_CENTER, $urandom, ($urandom_range(0, 3) == 0) ? $urandom :
                  ctr_x + $urandom_range(0, 4) - 2, ctr_z + $urandom_range(0, 4) - 2,
                  $urandom, $urandom);
      end else if (r < 94) begin
        send_beat(2'd3, $urandom, $urandom, $urandom, $urandom, $urandom);
      end else begin
        send_beat(ACT_CAMERA, $urandom, $urandom, $urandom, $urandom, $urandom);
      end
    end
  endtask

  // receiver holds off while the sender keeps pushing moves and drains
  task automatic test_holdoff();
    hold_request = 1'b1;
    for (int i = 0; i < 4; i++) begin
      send_camera_near(3, -2);
      while (pending_n > 0) send_camera_near(0, 0);
    end
  endtask

  // receiver stall, with a long hold-off on request
  int hold_left = 0;
  always @(posedge clk) begin
    if (hold_request) begin
      hold_request = 1'b0;
      hold_left = HOLDOFF;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(0, 99) < rx_stall_pct);
    end
  end

  // result monitor: each output beat against the oldest prediction
  always @(posedge clk) begin
    rebuild_t e;
    if (rst_n && out_valid && !out_stall) begin
      if (rebuild_q.size() == 0) begin
        $display("%0t unexpected beat: slot %0d tile (%0d,%0d)", $time,
                 out_slot, out_tile_x, out_tile_z);
        fail_count++;
      end else begin
        e = rebuild_q.pop_front();
        if (out_slot !== e.slot) begin
          $display("%0t slot mismatch: expected %0d actual %0d", $time, e.slot, out_slot);
          fail_count++;
        end
        if (out_tile_x !== e.tile_x) begin
          $display("%0t tile_x mismatch: expected %0d actual %0d", $time,
                   e.tile_x, out_tile_x);
          fail_count++;
        end
        if (out_tile_z !== e.tile_z) begin
          $display("%0t tile_z mismatch: expected %0d actual %0d", $time,
                   e.tile_z, out_tile_z);
          fail_count++;
        end
      end
    end
  end

  // watchdog: cycles with no beat on either channel
  int quiet_cycles = 0;
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) quiet_cycles = 0;
    else quiet_cycles++;
    if (quiet_cycles >= WDOG) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  initial begin
    span_reg  = SPAN_RESET;
    ctr_x     = '0;
    ctr_z     = '0;
    pending_n = 0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    tx_gap_pct   = 12;
    rx_stall_pct = 45;
    test_prime_slots();
    set_span(SPAN_RESET);
    test_directed();
    set_span(SPAN_RESET);
    test_random(300);
    test_holdoff();
    wait_drained();               // sender pause until all results are out

    tx_gap_pct   = 45;
    rx_stall_pct = 12;
    set_span(31'd1);
    test_random(150);
    set_span(31'($urandom_range(2, 40000)));
    test_random(200);

    tx_gap_pct   = 0;
    rx_stall_pct = 0;
    set_span(31'h7fffffff);
    test_random(100);
    set_span(SPAN_RESET);
    test_random(200);

    wait_drained();
    repeat (SETTLE) @(posedge clk);
    if (fail_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
